[hw/rtl/sfp_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor frame parser package
// Shared types and constants of the frame parser and its burst unit.
// ----------------------------------------------------------------------------
package sfp_pkg;

	// Fixed field widths of the result beat.
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 7;
	localparam int IDX_W     = 6;
	localparam int CFG_IDX_W = 1;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'd1;

	// Parser phases, one per byte position of a frame.
	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_DEV  = 3'd1,
		PH_SYS  = 3'd2,
		PH_MSG  = 3'd3,
		PH_SEQ  = 3'd4,
		PH_LEN  = 3'd5,
		PH_DATA = 3'd6,
		PH_SUM  = 3'd7
	} phase_t;

	// Command from the parser that starts a result burst.
	typedef struct packed {
		logic             start;
		logic [LEN_W-1:0] length;
	} sfp_burst_cmd_t;

	// Per-beat part of a result.
	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [BYTE_W-1:0] data;
		logic              has_payload;
		logic              last;
	} sfp_result_t;

endpackage

[hw/rtl/sfp_burst.sv]
// ----------------------------------------------------------------------------
// Frame parser payload buffer and burst reader
// Holds the payload bytes of the current frame in a synchronous memory and,
// on command, reads them back in order into a two-entry output queue.
// ----------------------------------------------------------------------------
module sfp_burst import sfp_pkg::*; #(
	parameter int MAX_PAYLOAD_BYTES = 64,
	localparam int AW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [BYTE_W-1:0]     wr_data,
	input  sfp_burst_cmd_t        cmd,
	output logic                  busy,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sfp_result_t           res
);

	logic [BYTE_W-1:0] mem [MAX_PAYLOAD_BYTES];

	logic              active_q;
	logic              has_q;
	logic [LEN_W-1:0]  rd_idx_q;
	logic [LEN_W-1:0]  count_q;
	logic              pend_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              has_s1;
	logic              last_s1;
	logic [BYTE_W-1:0] rd_data_s1;
	logic              out_v_q;
	logic              sp_v_q;
	sfp_result_t       out_q;
	sfp_result_t       sp_q;
	sfp_result_t       land;
	logic              pop;
	logic [1:0]        occ_after;
	logic              issue;
	logic              issue_last;

	// Write port, used while payload bytes arrive.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem[rd_idx_q[AW-1:0]];
		end
	end

	// A read is issued only when its beat is sure to find room in the queue.
	assign pop        = out_v_q && out_ready;
	assign occ_after  = 2'({1'b0, out_v_q}) + 2'({1'b0, sp_v_q}) + 2'({1'b0, pend_s1})
		- 2'({1'b0, pop});
	assign issue      = active_q && (occ_after < 2'd2);
	assign issue_last = (rd_idx_q + LEN_W'(1)) == count_q;

	// Read sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			has_q    <= 1'b0;
			rd_idx_q <= '0;
			count_q  <= '0;
			pend_s1  <= 1'b0;
		end else begin
			pend_s1 <= issue;
			if (cmd.start) begin
				active_q <= 1'b1;
				rd_idx_q <= '0;
				has_q    <= (cmd.length != '0);
				count_q  <= (cmd.length == '0) ? LEN_W'(1) : cmd.length;
			end else if (issue) begin
				rd_idx_q <= rd_idx_q + LEN_W'(1);
				if (issue_last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	// Beat details travel alongside the memory read.
	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= rd_idx_q[IDX_W-1:0];
			has_s1  <= has_q;
			last_s1 <= issue_last;
		end
	end

	// An empty frame reads as zero index and zero data.
	always_comb begin
		land.index       = has_s1 ? idx_s1 : '0;
		land.data        = has_s1 ? rd_data_s1 : '0;
		land.has_payload = has_s1;
		land.last        = last_s1;
	end

	// Output register with a spare entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sp_v_q  <= 1'b0;
		end else begin
			if (pop || !out_v_q) begin
				if (sp_v_q) begin
					out_v_q <= 1'b1;
					sp_v_q  <= pend_s1;
				end else begin
					out_v_q <= pend_s1;
				end
			end else if (pend_s1) begin
				sp_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !out_v_q) begin
			if (sp_v_q) begin
				out_q <= sp_q;
				if (pend_s1) begin
					sp_q <= land;
				end
			end else if (pend_s1) begin
				out_q <= land;
			end
		end else if (pend_s1) begin
			sp_q <= land;
		end
	end

	assign out_valid = out_v_q;
	assign res       = out_q;
	assign busy      = active_q || pend_s1 || out_v_q || sp_v_q;

	// The spare entry is only ever filled behind a held output beat.
	a_spare_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sp_v_q |-> out_v_q)
		else $error("spare entry valid with empty output register");

	// A landing read never finds both entries taken.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_s1 && sp_v_q && out_v_q && !pop))
		else $error("read data landed on a full output queue");

	// A new burst starts only after the previous one has drained.
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy)
		else $error("burst started while busy");

endmodule

[hw/rtl/sensor_frame_parser.sv]
// ----------------------------------------------------------------------------
// Sensor frame parser
// Byte-serial frame parser with an additive 8-bit checksum and payload burst.
// ----------------------------------------------------------------------------
// The parser takes one received byte per cycle while it hunts for the head
// byte and collects the four header bytes, the length and the payload. Payload
// bytes go into a single-port-write, registered-read memory. When the checksum
// byte matches, input stalls while the buffer is read back: a frame of L
// payload bytes yields L result beats (one beat for an empty frame), one per
// cycle while the sink is ready, the first one following the checksum beat
// through the read sequencer, the memory read and the output register.
// Input is held off after the checksum beat until the last result beat has
// been taken. A bad checksum or an over-long length costs nothing beyond
// its own byte. Configuration is always accepted.
module sensor_frame_parser import sfp_pkg::*; #(
	parameter int MAX_PAYLOAD_BYTES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    device_id,
	output logic [BYTE_W-1:0]    system_id,
	output logic [BYTE_W-1:0]    message_id,
	output logic [BYTE_W-1:0]    sequence_res,
	output logic [LEN_W-1:0]     payload_length,
	output logic [IDX_W-1:0]     byte_index,
	output logic [BYTE_W-1:0]    payload_byte,
	output logic                 has_payload,
	output logic                 last
);

	localparam int AW = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD_BYTES);

	phase_t            phase_q;
	phase_t            phase_d;
	logic [BYTE_W-1:0] head_byte_q;
	logic [LEN_W-1:0]  max_payload_q;
	logic [BYTE_W-1:0] hdr_device_q;
	logic [BYTE_W-1:0] hdr_system_q;
	logic [BYTE_W-1:0] hdr_message_q;
	logic [BYTE_W-1:0] hdr_sequence_q;
	logic [LEN_W-1:0]  frame_length_q;
	logic [LEN_W-1:0]  payload_count_q;
	logic [BYTE_W-1:0] running_sum_q;
	logic [LEN_W-1:0]  limit;
	logic [LEN_W-1:0]  count_inc;
	logic              in_fire;
	logic              len_too_long;
	logic              data_done;
	logic              sum_match;
	logic              burst_busy;
	logic              wr_en;
	sfp_burst_cmd_t    cmd;
	sfp_result_t       res;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_byte_q   <= BYTE_W'(239);
			max_payload_q <= LEN_W'(64);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_HEAD_BYTE:   head_byte_q   <= cfg_data;
				CFG_MAX_PAYLOAD: max_payload_q <= cfg_data[LEN_W-1:0];
				default:         ;
			endcase
		end
	end

	// Input handshake and per-byte decisions.
	assign in_ready     = !burst_busy;
	assign in_fire      = in_valid && in_ready;
	assign limit        = (max_payload_q > MAX_LEN) ? MAX_LEN : max_payload_q;
	assign len_too_long = rx_byte > {1'b0, limit};
	assign count_inc    = payload_count_q + LEN_W'(1);
	assign data_done    = count_inc >= frame_length_q;
	assign sum_match    = rx_byte == running_sum_q;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (in_fire) begin
			unique case (phase_q)
				PH_HUNT: phase_d = (rx_byte == head_byte_q) ? PH_DEV : PH_HUNT;
				PH_DEV:  phase_d = PH_SYS;
				PH_SYS:  phase_d = PH_MSG;
				PH_MSG:  phase_d = PH_SEQ;
				PH_SEQ:  phase_d = PH_LEN;
				PH_LEN: begin
					if (rx_byte == '0) begin
						phase_d = PH_SUM;
					end else if (len_too_long) begin
						phase_d = PH_HUNT;
					end else begin
						phase_d = PH_DATA;
					end
				end
				PH_DATA: phase_d = data_done ? PH_SUM : PH_DATA;
				PH_SUM:  phase_d = PH_HUNT;
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	// Phase outputs: buffer write and burst start.
	always_comb begin
		wr_en      = 1'b0;
		cmd.start  = 1'b0;
		cmd.length = frame_length_q;
		unique case (phase_q)
			PH_DATA: wr_en     = in_fire;
			PH_SUM:  cmd.start = in_fire && sum_match;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else begin
			phase_q <= phase_d;
		end
	end

	// Header capture, length, payload count and running checksum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_device_q    <= '0;
			hdr_system_q    <= '0;
			hdr_message_q   <= '0;
			hdr_sequence_q  <= '0;
			frame_length_q  <= '0;
			payload_count_q <= '0;
			running_sum_q   <= '0;
		end else if (in_fire) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == head_byte_q) begin
						running_sum_q   <= rx_byte;
						payload_count_q <= '0;
					end
				end
				PH_DEV: begin
					hdr_device_q  <= rx_byte;
					running_sum_q <= running_sum_q + rx_byte;
				end
				PH_SYS: begin
					hdr_system_q  <= rx_byte;
					running_sum_q <= running_sum_q + rx_byte;
				end
				PH_MSG: begin
					hdr_message_q <= rx_byte;
					running_sum_q <= running_sum_q + rx_byte;
				end
				PH_SEQ: begin
					hdr_sequence_q <= rx_byte;
					running_sum_q  <= running_sum_q + rx_byte;
				end
				PH_LEN: begin
					if (rx_byte == '0 || !len_too_long) begin
						frame_length_q  <= rx_byte[LEN_W-1:0];
						payload_count_q <= '0;
						running_sum_q   <= running_sum_q + rx_byte;
					end
				end
				PH_DATA: begin
					running_sum_q   <= running_sum_q + rx_byte;
					payload_count_q <= data_done ? '0 : count_inc;
				end
				default: ;
			endcase
		end
	end

	sfp_burst #(
		.MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
	) u_burst (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (payload_count_q[AW-1:0]),
		.wr_data   (rx_byte),
		.cmd       (cmd),
		.busy      (burst_busy),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	// Header fields stay put while the burst runs, since input is held off.
	assign device_id      = hdr_device_q;
	assign system_id      = hdr_system_q;
	assign message_id     = hdr_message_q;
	assign sequence_res   = hdr_sequence_q;
	assign payload_length = frame_length_q;
	assign byte_index     = res.index;
	assign payload_byte   = res.data;
	assign has_payload    = res.has_payload;
	assign last           = res.last;

	// While collecting payload the count stays below the frame length.
	a_count_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (payload_count_q < frame_length_q))
		else $error("payload count ran past the frame length");

	// A stored payload length never exceeds the buffer.
	a_length_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (frame_length_q <= MAX_LEN))
		else $error("frame length exceeds the payload buffer");

	// A good checksum beat always opens a burst.
	a_match_starts_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && phase_q == PH_SUM && sum_match) |=> (burst_busy && !in_ready))
		else $error("checksum match did not start a result burst");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Sensor frame parser testbench
// Drives byte streams of well-formed, corrupt, over-long and truncated frames
// into the parser under random idling and back pressure, predicts every result
// beat with a behavioral frame parser, and checks each beat field by field.
// ----------------------------------------------------------------------------
module testbench;
	import sfp_pkg::*;

	localparam int          MAX_BYTES   = 64;
	localparam int          HOLD_CYCLES = 300;
	localparam int          SETTLE_PAD  = 6;
	localparam int unsigned CYCLE_LIMIT = 400000;

	// One expected result beat.
	typedef struct {
		logic [BYTE_W-1:0] dev_id;
		logic [BYTE_W-1:0] sys_id;
		logic [BYTE_W-1:0] msg_id;
		logic [BYTE_W-1:0] seq_no;
		logic [LEN_W-1:0]  length;
		logic [IDX_W-1:0]  index;
		logic [BYTE_W-1:0] data;
		logic              has_data;
		logic              is_last;
	} frame_beat_t;

	// How the payload of a generated frame is filled.
	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_HEAD} fill_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [BYTE_W-1:0]    cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 out_valid;
	logic                 out_ready;
	logic [BYTE_W-1:0]    device_id;
	logic [BYTE_W-1:0]    system_id;
	logic [BYTE_W-1:0]    message_id;
	logic [BYTE_W-1:0]    sequence_res;
	logic [LEN_W-1:0]     payload_length;
	logic [IDX_W-1:0]     byte_index;
	logic [BYTE_W-1:0]    payload_byte;
	logic                 has_payload;
	logic                 last;

	// Behavioral parser state and register copies.
	logic [BYTE_W-1:0] head_value = 8'd239;
	logic [LEN_W-1:0]  max_value  = 7'd64;
	phase_t            cur_phase  = PH_HUNT;
	logic [BYTE_W-1:0] cap_device = '0;
	logic [BYTE_W-1:0] cap_system = '0;
	logic [BYTE_W-1:0] cap_message = '0;
	logic [BYTE_W-1:0] cap_sequence = '0;
	logic [LEN_W-1:0]  cap_length = '0;
	logic [LEN_W-1:0]  data_count = '0;
	logic [BYTE_W-1:0] csum = '0;
	logic [BYTE_W-1:0] data_buf [MAX_BYTES];

	frame_beat_t pending_beats[$];
	int unsigned error_count   = 0;
	int unsigned beats_seen    = 0;
	int unsigned bytes_taken   = 0;
	int unsigned ignored_bytes = 0;
	int unsigned cycle_count   = 0;
	bit          send_gaps     = 1'b1;
	bit          sink_gaps     = 1'b1;
	bit          hold_req      = 1'b0;

	sensor_frame_parser #(
		.MAX_PAYLOAD_BYTES(MAX_BYTES)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.device_id      (device_id),
		.system_id      (system_id),
		.message_id     (message_id),
		.sequence_res   (sequence_res),
		.payload_length (payload_length),
		.byte_index     (byte_index),
		.payload_byte   (payload_byte),
		.has_payload    (has_payload),
		.last           (last)
	);

	// Clock with a period of 12.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Largest payload length the parser accepts with the current register.
	function automatic int unsigned length_limit();
		return (max_value > MAX_BYTES) ? MAX_BYTES : max_value;
	endfunction

	// Advance the behavioral parser by one accepted byte and queue any beats.
	task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
		frame_beat_t beat;
		case (cur_phase)
			PH_HUNT: begin
				if (b == head_value) begin
					csum       = b;
					data_count = '0;
					cur_phase  = PH_DEV;
				end
			end
			PH_DEV: begin
				cap_device = b;
				csum      += b;
				cur_phase  = PH_SYS;
			end
			PH_SYS: begin
				cap_system = b;
				csum      += b;
				cur_phase  = PH_MSG;
			end
			PH_MSG: begin
				cap_message = b;
				csum       += b;
				cur_phase   = PH_SEQ;
			end
			PH_SEQ: begin
				cap_sequence = b;
				csum        += b;
				cur_phase    = PH_LEN;
			end
			PH_LEN: begin
				if (b == 8'd0) begin
					cap_length = '0;
					cur_phase  = PH_SUM;
				end else if (b > length_limit()) begin
					cur_phase = PH_HUNT;
				end else begin
					cap_length = b[LEN_W-1:0];
					data_count = '0;
					csum      += b;
					cur_phase  = PH_DATA;
				end
			end
			PH_DATA: begin
				if (data_count < MAX_BYTES)
					data_buf[data_count] = b;
				data_count = data_count + 1'b1;
				csum      += b;
				if (data_count >= cap_length) begin
					data_count = '0;
					cur_phase  = PH_SUM;
				end
			end
			PH_SUM: begin
				cur_phase = PH_HUNT;
				if (b == csum) begin
					beat.dev_id = cap_device;
					beat.sys_id = cap_system;
					beat.msg_id = cap_message;
					beat.seq_no = cap_sequence;
					beat.length = cap_length;
					if (cap_length == 0) begin
						beat.index    = '0;
						beat.data     = '0;
						beat.has_data = 1'b0;
						beat.is_last  = 1'b1;
						pending_beats.push_back(beat);
					end else begin
						for (int i = 0; i < cap_length; i++) begin
							beat.index    = i[IDX_W-1:0];
							beat.data     = data_buf[i];
							beat.has_data = 1'b1;
							beat.is_last  = (i + 1 == cap_length);
							pending_beats.push_back(beat);
						end
					end
				end
			end
			default: begin
				cur_phase  = PH_HUNT;
				data_count = '0;
			end
		endcase
	endtask

	// Offer one byte after a random gap and hold it until it is accepted.
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int unsigned gap;
		gap = send_gaps ? pick_gap() : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_taken++;
		parse_rx_byte(b);
	endtask

	// Send one frame; an over-long length ends it right after the length byte.
	task automatic send_frame(input logic [BYTE_W-1:0] dev, sys, msg, seq,
			input int unsigned len, input fill_t fill, input bit bad_sum);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		sum = head_value + dev + sys + msg + seq + len[BYTE_W-1:0];
		send_byte(head_value);
		send_byte(dev);
		send_byte(sys);
		send_byte(msg);
		send_byte(seq);
		send_byte(len[BYTE_W-1:0]);
		if (len > length_limit())
			return;
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				FILL_HEAD: b = head_value;
				default:   b = $urandom_range(0, 255);
			endcase
			sum += b;
			send_byte(b);
		end
		if (bad_sum)
			sum += $urandom_range(1, 255);
		send_byte(sum);
	endtask

	// Random frame, mostly short, sometimes up to or past the length limit.
	task automatic send_random_frame();
		int unsigned lim;
		int unsigned len;
		int unsigned r;
		lim = length_limit();
		r   = $urandom_range(0, 99);
		if (r < 10 || lim == 0)
			len = 0;
		else if (r < 75)
			len = $urandom_range(1, (lim < 8) ? lim : 8);
		else if (r < 88)
			len = $urandom_range(1, lim);
		else
			len = $urandom_range(lim + 1, 255);
		send_frame($urandom_range(0, 255), $urandom_range(0, 255),
			$urandom_range(0, 255), $urandom_range(0, 255), len, FILL_RANDOM,
			$urandom_range(0, 99) < 20);
	endtask

	// Stop sending, wait for every expected beat, then let the pipeline empty.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_PAD) @(posedge clk);
	endtask

	// One write beat on the configuration port.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == CFG_HEAD_BYTE)
			head_value = value;
		else
			max_value = value[LEN_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(input logic [BYTE_W-1:0] head, input logic [BYTE_W-1:0] max_len);
		settle();
		write_reg(CFG_HEAD_BYTE, head);
		write_reg(CFG_MAX_PAYLOAD, max_len);
	endtask

	// Reset register values: empty, short, dropped and bad frames.
	task automatic test_default_frames();
		send_gaps = 1'b1;
		sink_gaps = 1'b1;
		// Stray bytes while hunting are ignored.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(8'h00, 8'h00, 8'h00, 8'h00, 0, FILL_RANDOM, 1'b0);
		send_frame(8'h12, 8'h34, 8'h56, 8'h78, 0, FILL_RANDOM, 1'b1);
		send_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, FILL_ONES, 1'b0);
		send_frame(8'hA5, 8'h5A, 8'h3C, 8'hC3, 8, FILL_ZERO, 1'b0);
		send_frame(8'h01, 8'h02, 8'h03, 8'h04, 65, FILL_RANDOM, 1'b0);
		send_frame(8'h80, 8'h40, 8'h20, 8'h10, 255, FILL_RANDOM, 1'b0);
		// Head byte values inside the payload are plain data.
		send_frame(8'h11, 8'h22, 8'h33, 8'h44, 5, FILL_HEAD, 1'b0);
		send_frame(8'h55, 8'h66, 8'h77, 8'h88, 3, FILL_RANDOM, 1'b1);
	endtask

	// Register extremes, including a zero limit and limits above the buffer.
	task automatic test_register_extremes();
		set_config(8'h00, 8'd1);
		send_frame(8'h01, 8'h02, 8'h03, 8'h04, 1, FILL_RANDOM, 1'b0);
		send_frame(8'h05, 8'h06, 8'h07, 8'h08, 2, FILL_RANDOM, 1'b0);
		set_config(8'hFF, 8'd0);
		send_frame(8'h09, 8'h0A, 8'h0B, 8'h0C, 0, FILL_RANDOM, 1'b0);
		send_frame(8'h0D, 8'h0E, 8'h0F, 8'h10, 1, FILL_RANDOM, 1'b0);
		set_config(8'hA5, 8'd127);
		send_frame(8'hC0, 8'hDE, 8'hBE, 8'hEF, 64, FILL_RANDOM, 1'b0);
		send_frame(8'h21, 8'h43, 8'h65, 8'h87, 65, FILL_RANDOM, 1'b0);
		// Bit 7 of the write data is dropped, leaving 72, which the buffer clamps to a limit of 64.
		set_config(8'h5A, 8'd200);
		send_frame(8'h31, 8'h32, 8'h33, 8'h34, 2, FILL_RANDOM, 1'b0);
		send_frame(8'h35, 8'h36, 8'h37, 8'h38, 65, FILL_RANDOM, 1'b0);
		set_config(8'd239, 8'd64);
	endtask

	// Long sink hold-off while good frames keep coming, so input stalls.
	task automatic test_sink_holdoff();
		settle();
		send_gaps = 1'b0;
		sink_gaps = 1'b0;
		hold_req  = 1'b1;
		repeat (2)
			send_frame($urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), $urandom_range(0, 255), 4, FILL_RANDOM, 1'b0);
		settle();
	endtask

	// Mostly well-formed random frames, with stray bytes and cut-off frames.
	task automatic run_random_round(input logic [BYTE_W-1:0] head,
			input logic [BYTE_W-1:0] max_len, input bit gaps, input int unsigned n_bytes);
		int unsigned byte_start;
		int unsigned beat_start;
		int unsigned r;
		int unsigned k;
		logic [BYTE_W-1:0] stray;
		set_config(head, max_len);
		send_gaps  = gaps;
		sink_gaps  = gaps;
		byte_start = bytes_taken - ignored_bytes;
		beat_start = beats_seen;
		while ((bytes_taken - ignored_bytes - byte_start < n_bytes ||
				beats_seen - beat_start < 3) &&
				bytes_taken - ignored_bytes - byte_start < 20 * n_bytes) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				do
					stray = $urandom_range(0, 255);
				while (stray == head_value);
				send_byte(stray);
				ignored_bytes++;
			end else if (r < 16) begin
				k = $urandom_range(1, 4);
				send_byte(head_value);
				repeat (k)
					send_byte($urandom_range(0, 255));
			end else begin
				send_random_frame();
			end
		end
		settle();
	endtask

	task automatic test_random_traffic();
		run_random_round($urandom_range(0, 255), $urandom_range(16, 64), 1'b1, 8);
		run_random_round($urandom_range(0, 255), 8'd64, 1'b0, 8);
		run_random_round($urandom_range(0, 255), $urandom_range(1, 12), 1'b1, 8);
	endtask

	// Sink side: random stalls, plus one long hold-off on request.
	initial begin
		int unsigned stall_left;
		int unsigned hold_left;
		stall_left = 0;
		hold_left  = 0;
		out_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && hold_left == 0) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (sink_gaps && $urandom_range(0, 99) < 30) begin
				stall_left = pick_gap();
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic void check_field(input string name, input int unsigned expected,
			input int unsigned actual);
		if (expected != actual) begin
			$error("%s: expected %0d, actual %0d", name, expected, actual);
			error_count++;
		end
	endfunction

	// Compare each result beat with the oldest expected one.
	always @(posedge clk) begin : check_results
		frame_beat_t exp_beat;
		if (arst_n && out_valid && out_ready) begin
			beats_seen++;
			if (pending_beats.size() == 0) begin
				$error("result beat arrived with no beat expected");
				error_count++;
			end else begin
				exp_beat = pending_beats.pop_front();
				check_field("device_id", exp_beat.dev_id, device_id);
				check_field("system_id", exp_beat.sys_id, system_id);
				check_field("message_id", exp_beat.msg_id, message_id);
				check_field("sequence_res", exp_beat.seq_no, sequence_res);
				check_field("payload_length", exp_beat.length, payload_length);
				check_field("byte_index", exp_beat.index, byte_index);
				check_field("payload_byte", exp_beat.data, payload_byte);
				check_field("has_payload", exp_beat.has_data, has_payload);
				check_field("last", exp_beat.is_last, last);
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		rx_byte   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_frames();
		test_register_extremes();
		test_sink_holdoff();
		test_random_traffic();
		settle();

		if (pending_beats.size() != 0) begin
			$error("%0d expected beats never arrived", pending_beats.size());
			error_count++;
		end
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
